[design/rsr_pkg.sv]
`default_nettype none

package rsr_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_PERIOD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RETRY_LIMIT  = 1'd1;

    localparam logic [15:0] CHECK_PERIOD_RST = 16'd1000;
    localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd3;
    localparam logic [31:0] RESTART_DELAY    = 32'd1000;
    localparam logic [31:0] DISARMED         = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_SET    = 2'd1,
        ACT_TOGGLE = 2'd2,
        ACT_ARM    = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic        close_request;
        logic [31:0] timeout_ms;
        logic        feedback_level;
    } t_item;

    typedef struct packed {
        logic       coil_drive;
        logic       fault;
        logic       fault_event;
        logic [7:0] retries_left;
    } t_result;

endpackage

`default_nettype wire

[design/relay_supervisor_with_retry_unit.sv]
`default_nettype none

// Supervisor for a monostable relay with feedback checking and retries. Each word
// is a millisecond tick carrying the feedback level, a set or toggle command, or
// the arming of a one-shot toggle. Every accepted word yields exactly one result
// word holding the coil drive, the fault flag, a fault change pulse and the
// remaining retries. A word is registered in the input register on acceptance;
// its result is registered in the output register when the core fires. One word
// is taken in every cycle unless the output stalls, a rate the core's state
// update sets. An output register separates the two channels; configuration is
// written through a simple write port (index 0 check period, index 1 retry limit).
module relay_supervisor_with_retry_unit
    import rsr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_action,
    input  wire logic                  i_close_request,
    input  wire logic [31:0]           i_timeout_ms,
    input  wire logic                  i_feedback_level,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_coil_drive,
    output logic                       o_fault,
    output logic                       o_fault_event,
    output logic [7:0]                 o_retries_left
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    logic    fire;
    t_result result;
    t_result r_out;
    logic    r_out_valid;

    assign in_item.action         = t_action'(i_action);
    assign in_item.close_request  = i_close_request;
    assign in_item.timeout_ms     = i_timeout_ms;
    assign in_item.feedback_level = i_feedback_level;

    assign advance = !r_out_valid || i_out_ready;
    assign fire    = held_valid && advance;

    rsr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    rsr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_item        (held_item),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coil_drive   = r_out.coil_drive;
    assign o_fault        = r_out.fault;
    assign o_fault_event  = r_out.fault_event;
    assign o_retries_left = r_out.retries_left;

endmodule

`default_nettype wire

[design/rsr_in_reg.sv]
`default_nettype none

module rsr_in_reg
    import rsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[design/rsr_core.sv]
`default_nettype none

module rsr_core
    import rsr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  wire logic                  i_fire,
    input  wire t_item                 i_item,
    output t_result                    o_result
);

    logic [15:0] r_check_period;
    logic [7:0]  r_retry_limit;

    logic [31:0] r_time_now;
    logic        r_cmd_closed;
    logic [31:0] r_toggle_due;
    logic [31:0] r_check_due;
    logic [7:0]  r_retry_count;
    logic        r_fault;

    logic [31:0] n_time_now;
    logic        n_cmd_closed;
    logic [31:0] n_toggle_due;
    logic [31:0] n_check_due;
    logic [7:0]  n_retry_count;
    logic        n_fault;
    logic        event_pulse;

    logic [31:0] time_inc;
    logic [32:0] restart_sum;
    logic [31:0] period_due;
    logic [31:0] now_restart;
    logic        toggle_hit;
    logic        check_hit;
    logic        fb_closed;
    logic [7:0]  retry_dec;

    assign time_inc    = r_time_now + 32'd1;
    assign restart_sum = {1'b0, time_inc} + {1'b0, RESTART_DELAY};
    assign period_due  = time_inc + {16'd0, r_check_period};
    assign now_restart = r_time_now + RESTART_DELAY;
    assign toggle_hit  = time_inc > r_toggle_due;
    // After a timer toggle the check due time is now plus the restart delay,
    // which the new time exceeds only when that sum has wrapped.
    assign check_hit   = toggle_hit ? restart_sum[32] : (time_inc > r_check_due);
    assign fb_closed   = !i_item.feedback_level;
    assign retry_dec   = (r_retry_count != 8'd0) ? r_retry_count - 8'd1 : 8'd0;

    always_comb begin
        n_time_now    = r_time_now;
        n_cmd_closed  = r_cmd_closed;
        n_toggle_due  = r_toggle_due;
        n_check_due   = r_check_due;
        n_retry_count = r_retry_count;
        n_fault       = r_fault;
        event_pulse   = 1'b0;
        case (i_item.action)
            ACT_TICK: begin
                n_time_now = time_inc;
                if (toggle_hit) begin
                    n_toggle_due = DISARMED;
                    n_cmd_closed = !r_cmd_closed;
                    n_check_due  = restart_sum[31:0];
                end
                if (check_hit) begin
                    if (fb_closed != n_cmd_closed) begin
                        if (!r_fault) begin
                            n_retry_count = retry_dec;
                            if (retry_dec == 8'd0) begin
                                n_fault     = 1'b1;
                                event_pulse = 1'b1;
                            end
                        end
                    end else begin
                        if (r_fault) begin
                            n_fault     = 1'b0;
                            event_pulse = 1'b1;
                        end
                        n_retry_count = r_retry_limit;
                    end
                    n_check_due = period_due;
                end
            end
            ACT_SET: begin
                n_cmd_closed = i_item.close_request;
                n_check_due  = now_restart;
            end
            ACT_TOGGLE: begin
                n_cmd_closed = !r_cmd_closed;
                n_check_due  = now_restart;
            end
            ACT_ARM: begin
                n_toggle_due = r_time_now + i_item.timeout_ms;
            end
            default: begin
                n_time_now = r_time_now;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_period <= CHECK_PERIOD_RST;
            r_retry_limit  <= RETRY_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_CHECK_PERIOD: r_check_period <= i_cfg_wr_data;
                CFG_RETRY_LIMIT:  r_retry_limit  <= i_cfg_wr_data[7:0];
                default: begin
                    r_retry_limit <= r_retry_limit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_now    <= 32'd0;
            r_cmd_closed  <= 1'b0;
            r_toggle_due  <= DISARMED;
            r_check_due   <= RESTART_DELAY;
            r_retry_count <= RETRY_LIMIT_RST;
            r_fault       <= 1'b0;
        end else if (i_fire) begin
            r_time_now    <= n_time_now;
            r_cmd_closed  <= n_cmd_closed;
            r_toggle_due  <= n_toggle_due;
            r_check_due   <= n_check_due;
            r_retry_count <= n_retry_count;
            r_fault       <= n_fault;
        end
    end

    assign o_result.coil_drive   = n_cmd_closed;
    assign o_result.fault        = n_fault;
    assign o_result.fault_event  = event_pulse;
    assign o_result.retries_left = n_retry_count;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
module testbench;
    import rsr_pkg::*;

    // Predicts the result word of every accepted input word and holds the predictions in order.
    class relay_status_board;
        logic [15:0] check_period;
        logic [7:0]  retry_limit;
        logic [31:0] time_now;
        logic        commanded_closed;
        logic [31:0] toggle_due;
        logic [31:0] check_due;
        logic [7:0]  retry_count;
        logic        fault_flag;
        t_result     expected_status[$];
        int          errors;

        function new();
            check_period     = CHECK_PERIOD_RST;
            retry_limit      = RETRY_LIMIT_RST;
            time_now         = '0;
            commanded_closed = 1'b0;
            toggle_due       = DISARMED;
            check_due        = RESTART_DELAY;
            retry_count      = RETRY_LIMIT_RST;
            fault_flag       = 1'b0;
            errors           = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_CHECK_PERIOD: check_period = data[15:0];
                CFG_RETRY_LIMIT: retry_limit = data[7:0];
                default: ;
            endcase
        endfunction

        function void drive_coil(logic closed);
            commanded_closed = closed;
            check_due        = time_now + RESTART_DELAY;
        endfunction

        function void note_word(t_item w);
            t_result r;
            logic    fault_change;
            fault_change = 1'b0;
            case (w.action)
                ACT_TICK: begin
                    time_now = time_now + 32'd1;
                    if (time_now > toggle_due) begin
                        toggle_due = DISARMED;
                        drive_coil(~commanded_closed);
                    end
                    if (time_now > check_due) begin
                        // A low feedback level means the contacts are closed.
                        if (~w.feedback_level != commanded_closed) begin
                            if (!fault_flag) begin
                                drive_coil(commanded_closed);
                                if (retry_count > 8'd0)
                                    retry_count = retry_count - 8'd1;
                                if (retry_count == 8'd0) begin
                                    fault_flag   = 1'b1;
                                    fault_change = 1'b1;
                                end
                            end
                        end else begin
                            if (fault_flag) begin
                                fault_flag   = 1'b0;
                                fault_change = 1'b1;
                            end
                            retry_count = retry_limit;
                        end
                        check_due = time_now + {16'd0, check_period};
                    end
                end
                ACT_SET: drive_coil(w.close_request);
                ACT_TOGGLE: drive_coil(~commanded_closed);
                default: toggle_due = time_now + w.timeout_ms;
            endcase
            r.coil_drive   = commanded_closed;
            r.fault        = fault_flag;
            r.fault_event  = fault_change;
            r.retries_left = retry_count;
            expected_status.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_status(t_result got);
            t_result want;
            if (expected_status.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = expected_status.pop_front();
            if (got.coil_drive !== want.coil_drive)
                report_mismatch($sformatf("coil_drive %b, expected %b",
                                          got.coil_drive, want.coil_drive));
            if (got.fault !== want.fault)
                report_mismatch($sformatf("fault %b, expected %b", got.fault, want.fault));
            if (got.fault_event !== want.fault_event)
                report_mismatch($sformatf("fault_event %b, expected %b",
                                          got.fault_event, want.fault_event));
            if (got.retries_left !== want.retries_left)
                report_mismatch($sformatf("retries_left %0d, expected %0d",
                                          got.retries_left, want.retries_left));
        endtask
    endclass

    localparam int WORD_TARGET = 1500;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_action = '0;
    logic                  i_close_request = 1'b0;
    logic [31:0]           i_timeout_ms = '0;
    logic                  i_feedback_level = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_coil_drive;
    logic                  o_fault;
    logic                  o_fault_event;
    logic [7:0]            o_retries_left;

    relay_status_board board;
    int                burst_left = 0;
    int                words_sent = 0;
    logic [15:0]       stall_mask = '0;
    int unsigned       stall_phase = 0;

    relay_supervisor_with_retry_unit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_status(t_result'{o_coil_drive, o_fault, o_fault_event, o_retries_left});
        stall_phase++;
        if (stall_phase % 200 == 0)
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        i_out_ready <= ~stall_mask[stall_phase % 16];
    end

    function automatic t_item word(t_action a, logic c, logic [31:0] t, logic f);
        t_item w;
        w.action         = a;
        w.close_request  = c;
        w.timeout_ms     = t;
        w.feedback_level = f;
        return w;
    endfunction

    function automatic t_item tick_word(logic level);
        return word(ACT_TICK, 1'($urandom), $urandom, level);
    endfunction

    function automatic t_item random_command();
        logic [31:0] tmo;
        case ($urandom_range(0, 3))
            0, 1: tmo = $urandom_range(0, 50);
            2: tmo = $urandom_range(0, 1500);
            default: tmo = $urandom;
        endcase
        return word(t_action'($urandom_range(1, 3)), 1'($urandom), tmo, 1'($urandom));
    endfunction

    task automatic send_word(t_item w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_action         <= w.action;
        i_close_request  <= w.close_request;
        i_timeout_ms     <= w.timeout_ms;
        i_feedback_level <= w.feedback_level;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_word(w);
        words_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.expected_status.size() != 0);
    endtask

    task automatic write_register(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= index;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        board.set_register(index, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_episode(input int e);
        logic [15:0] period;
        logic [7:0]  limit;
        int          mismatch_pct;
        int          n;
        int          roll;
        wait_idle();
        case (e)
            0: begin period = 16'd1;     limit = 8'd0;   end
            1: begin period = 16'd0;     limit = 8'd255; end
            2: begin period = 16'd65535; limit = 8'd1;   end
            3: begin period = 16'd2;     limit = 8'd3;   end
            default: begin
                period = 16'($urandom_range(1, 6));
                limit  = 8'($urandom_range(0, 4));
            end
        endcase
        write_register(CFG_CHECK_PERIOD, period);
        write_register(CFG_RETRY_LIMIT, {8'($urandom), limit});
        case ($urandom_range(0, 4))
            0: mismatch_pct = 0;
            1: mismatch_pct = 20;
            2: mismatch_pct = 50;
            3: mismatch_pct = 85;
            default: mismatch_pct = 100;
        endcase
        // A command brings a far-off check back to within a second.
        if (board.check_due - board.time_now > RESTART_DELAY)
            send_word(word(ACT_TOGGLE, 1'($urandom), $urandom, 1'($urandom)));
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 2)) send_word(random_command());
        while (board.time_now < board.check_due && words_sent < WORD_TARGET)
            send_word(tick_word(1'($urandom)));
        n = $urandom_range(150, 400);
        for (int i = 0; i < n && words_sent < WORD_TARGET; i++) begin
            if (e == 1 && i == n / 2)
                wait_idle();
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_word(random_command());
            else if (roll < 10)
                send_word(tick_word(1'($urandom)));
            else if ($urandom_range(1, 100) <= mismatch_pct)
                send_word(tick_word(board.commanded_closed));
            else
                send_word(tick_word(~board.commanded_closed));
        end
    endtask

    initial begin
        int e;
        e = 0;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // An all-ones timeout at time zero lands exactly on the disarmed value.
        send_word(word(ACT_ARM, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_word(word(ACT_TICK, 1'b0, 32'h0000_0000, 1'b0));
        send_word(word(ACT_ARM, 1'b0, 32'h0000_0000, 1'b0));
        send_word(word(ACT_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_word(word(ACT_ARM, 1'b1, 32'hFFFF_FFFF, 1'b0));
        send_word(word(ACT_TICK, 1'b0, 32'h5555_5555, 1'b1));
        send_word(word(ACT_SET, 1'b1, 32'hAAAA_AAAA, 1'b1));
        send_word(word(ACT_SET, 1'b0, 32'h5555_5555, 1'b0));
        send_word(word(ACT_TOGGLE, 1'b0, 32'hFFFF_FFFF, 1'b1));
        send_word(word(ACT_TOGGLE, 1'b1, 32'h0000_0000, 1'b0));
        send_word(word(ACT_ARM, 1'b0, ~board.time_now, 1'b1));
        send_word(word(ACT_TICK, 1'b1, 32'hAAAA_AAAA, 1'b0));
        send_word(word(ACT_TICK, 1'b0, 32'h0000_0000, 1'b1));
        send_word(word(ACT_ARM, 1'b1, 32'h8000_0000, 1'b0));
        send_word(word(ACT_ARM, 1'b0, 32'd2, 1'b1));
        repeat (3) send_word(tick_word(1'($urandom)));

        while (words_sent < WORD_TARGET) begin
            run_episode(e);
            e++;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #5000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
